### rtl/core/imurmv_pkg.sv
// ----------------------------------------------------------------------------
// imurmv_pkg
// shared widths, constants and types of the imu running mean / variance core
// ----------------------------------------------------------------------------
package imurmv_pkg;

  // sample counter width
  localparam int COUNT_BITS = 16;

  localparam int AXES      = 6;
  localparam int AXIS_W    = 3;
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 8;
  localparam int MEAN_W    = 24;
  localparam int VAR_W     = 40;

  // signed difference of a scaled sample and a mean
  localparam int DIFF_W = SAMPLE_W + FRAC_BITS + 1;
  // squared error after dropping the fraction bits
  localparam int E2_W   = 2 * DIFF_W - FRAC_BITS;
  // dividend register of the shared divider
  localparam int DVD_W  = E2_W;
  // width of an iteration count
  localparam int LEN_W  = $clog2(DVD_W + 1);

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

### rtl/core/imu_running_mean_variance_core.sv
// ----------------------------------------------------------------------------
// imu_running_mean_variance_core
// running per-axis mean and variance of six-axis imu samples
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_stall_o carry one sample transaction, the
//   restart flag plus three accel and three gyro axes in raw signed counts
//   output channel: out_valid_o / out_stall_i carry the six running means
//   (q8) and six running variances (q8, saturating at 2^40-1)
//   one transaction in gives exactly one transaction out
//   a new sample is accepted only after the result of the last one has been
//   handed over; each axis uses the shared one-bit-per-cycle divider four
//   times (mean step, two ceil corrections and the final divide by n)
//   in_stall_o is high while a sample is being worked on or its result waits
//   for hand-over; a result held by a stalled receiver does not block the
//   next sample; only the hand-over of the following result waits until the
//   receiver frees it
//   reset: count returns to one, all means and variances to zero, no result pending
// ----------------------------------------------------------------------------
module imu_running_mean_variance_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  input  logic [15:0] accel_x_i,
  input  logic [15:0] accel_y_i,
  input  logic [15:0] accel_z_i,
  input  logic [15:0] gyro_x_i,
  input  logic [15:0] gyro_y_i,
  input  logic [15:0] gyro_z_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] accel_mean_x_o,
  output logic [23:0] accel_mean_y_o,
  output logic [23:0] accel_mean_z_o,
  output logic [23:0] gyro_mean_x_o,
  output logic [23:0] gyro_mean_y_o,
  output logic [23:0] gyro_mean_z_o,
  output logic [39:0] accel_var_x_o,
  output logic [39:0] accel_var_y_o,
  output logic [39:0] accel_var_z_o,
  output logic [39:0] gyro_var_x_o,
  output logic [39:0] gyro_var_y_o,
  output logic [39:0] gyro_var_z_o
);

  localparam int CW   = imurmv_pkg::COUNT_BITS;
  localparam int DW   = imurmv_pkg::DIFF_W;
  localparam int MW   = imurmv_pkg::MEAN_W;
  localparam int VW   = imurmv_pkg::VAR_W;
  localparam int QW   = imurmv_pkg::DVD_W;
  localparam int SW   = imurmv_pkg::SAMPLE_W;
  localparam int AW   = imurmv_pkg::AXIS_W;
  localparam int NAX  = imurmv_pkg::AXES;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a sample
  localparam logic [2:0] S_MDIV   = 3'd1;  // start |x - mean| / n
  localparam logic [2:0] S_MWAIT  = 3'd2;  // new mean, error magnitude
  localparam logic [2:0] S_SQ     = 3'd3;  // square error, start var / n
  localparam logic [2:0] S_V1WAIT = 3'd4;  // t1, start e2 / n
  localparam logic [2:0] S_V2WAIT = 3'd5;  // e2*(n-1)/n, start it / n
  localparam logic [2:0] S_V3WAIT = 3'd6;  // add, saturate, next axis
  localparam logic [2:0] S_DONE   = 3'd7;  // hand result to output register

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       axis_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       n_q;
  logic [CW-1:0]       n_acc;
  logic [SW-1:0]       samp_q [NAX];
  logic [MW-1:0]       mean_q [NAX];
  logic [VW-1:0]       var_q  [NAX];
  logic [MW-1:0]       out_mean_q [NAX];
  logic [VW-1:0]       out_var_q  [NAX];
  logic                out_valid_q;
  logic [DW-1:0]       e_mag_q;
  logic [QW-1:0]       e2_q;
  logic [VW-1:0]       t1_q;

  logic                in_acc;
  logic                out_free;

  // datapath of the current axis
  logic signed [DW-1:0] xq_s;
  logic signed [DW-1:0] mean_s;
  logic signed [DW-1:0] d_s;
  logic [DW-1:0]        d_mag;
  logic [DW-1:0]        q_step;
  logic signed [DW-1:0] mean_new_s;
  logic signed [DW-1:0] e_s;
  logic [DW-1:0]        e_mag;
  logic [2*DW-1:0]      sq;
  logic [VW-1:0]        var_cur;
  logic [VW-1:0]        ceil_v;
  logic [QW-1:0]        u_d;
  logic [QW:0]          sum_v;
  logic [VW-1:0]        var_new;

  imurmv_pkg::div_req_t          div_req;
  imurmv_pkg::div_rsp_t          div_rsp;
  logic [QW-1:0]                 div_dvd;
  logic [QW-1:0]                 div_quo;
  logic [CW-1:0]                 div_rem;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // divisor for this sample: restart forces one, zero is taken as one
  always_comb begin
    n_acc = restart_i ? CW'(1) : count_q;
    if (n_acc == '0) begin
      n_acc = CW'(1);
    end
  end

  // scaled sample and mean, sign extended to the difference width
  assign xq_s   = {samp_q[axis_q][SW-1], samp_q[axis_q], {imurmv_pkg::FRAC_BITS{1'b0}}};
  assign mean_s = {mean_q[axis_q][MW-1], mean_q[axis_q]};
  assign d_s    = xq_s - mean_s;
  assign d_mag  = d_s[DW-1] ? DW'(-d_s) : DW'(d_s);

  // truncating division: apply the sign of the difference to |d| / n
  assign q_step     = d_s[DW-1] ? DW'(-div_quo[DW-1:0]) : div_quo[DW-1:0];
  assign mean_new_s = mean_s + $signed(q_step);
  assign e_s        = xq_s - mean_new_s;
  assign e_mag      = e_s[DW-1] ? DW'(-e_s) : DW'(e_s);

  assign sq = e_mag_q * e_mag_q;

  // floor(a*(n-1)/n) = a - ceil(a/n)
  assign var_cur = var_q[axis_q];
  assign ceil_v  = div_quo[VW-1:0] + VW'(div_rem != '0);
  assign u_d     = e2_q - (div_quo + QW'(div_rem != '0));

  assign sum_v   = {{(QW + 1 - VW){1'b0}}, t1_q} + {1'b0, div_quo};
  assign var_new = (sum_v[QW:VW] != '0) ? imurmv_pkg::VAR_MAX : sum_v[VW-1:0];

  // shared divider requests, dividends aligned to the msb
  always_comb begin
    div_req.start = 1'b0;
    div_req.len   = '0;
    div_dvd       = '0;
    case (state_q)
      S_MDIV: begin
        div_req.start = 1'b1;
        div_req.len   = imurmv_pkg::LEN_W'(DW);
        div_dvd       = {d_mag, {(QW - DW){1'b0}}};
      end
      S_SQ: begin
        div_req.start = 1'b1;
        div_req.len   = imurmv_pkg::LEN_W'(VW);
        div_dvd       = {var_cur, {(QW - VW){1'b0}}};
      end
      S_V1WAIT: begin
        div_req.start = div_rsp.done;
        div_req.len   = imurmv_pkg::LEN_W'(QW);
        div_dvd       = e2_q;
      end
      S_V2WAIT: begin
        div_req.start = div_rsp.done;
        div_req.len   = imurmv_pkg::LEN_W'(QW);
        div_dvd       = u_d;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  imurmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (n_q),
    .rsp_o      (div_rsp),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_MDIV;
      S_MDIV:   state_d = S_MWAIT;
      S_MWAIT:  if (div_rsp.done) state_d = S_SQ;
      S_SQ:     state_d = S_V1WAIT;
      S_V1WAIT: if (div_rsp.done) state_d = S_V2WAIT;
      S_V2WAIT: if (div_rsp.done) state_d = S_V3WAIT;
      S_V3WAIT: begin
        if (div_rsp.done) begin
          state_d = (axis_q == AW'(NAX - 1)) ? S_DONE : S_MDIV;
        end
      end
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
      for (int k = 0; k < NAX; k++) begin
        mean_q[k] <= '0;
        var_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        axis_q  <= '0;
        // count saturates at its all-ones value
        count_q <= (n_acc != {CW{1'b1}}) ? n_acc + 1'b1 : n_acc;
      end
      if (state_q == S_MWAIT && div_rsp.done) begin
        mean_q[axis_q] <= mean_new_s[MW-1:0];
      end
      if (state_q == S_V3WAIT && div_rsp.done) begin
        var_q[axis_q] <= var_new;
        axis_q        <= axis_q + 1'b1;
      end
      // a new result replaces one taken at the same edge
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q       <= n_acc;
      samp_q[0] <= accel_x_i;
      samp_q[1] <= accel_y_i;
      samp_q[2] <= accel_z_i;
      samp_q[3] <= gyro_x_i;
      samp_q[4] <= gyro_y_i;
      samp_q[5] <= gyro_z_i;
    end
    if (state_q == S_MWAIT && div_rsp.done) begin
      e_mag_q <= e_mag;
    end
    if (state_q == S_SQ) begin
      e2_q <= sq[2*DW-1:imurmv_pkg::FRAC_BITS];
    end
    if (state_q == S_V1WAIT && div_rsp.done) begin
      t1_q <= var_cur - ceil_v;
    end
    if (state_q == S_DONE && out_free) begin
      for (int k = 0; k < NAX; k++) begin
        out_mean_q[k] <= mean_q[k];
        out_var_q[k]  <= var_q[k];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accel_mean_x_o = out_mean_q[0];
  assign accel_mean_y_o = out_mean_q[1];
  assign accel_mean_z_o = out_mean_q[2];
  assign gyro_mean_x_o  = out_mean_q[3];
  assign gyro_mean_y_o  = out_mean_q[4];
  assign gyro_mean_z_o  = out_mean_q[5];
  assign accel_var_x_o  = out_var_q[0];
  assign accel_var_y_o  = out_var_q[1];
  assign accel_var_z_o  = out_var_q[2];
  assign gyro_var_x_o   = out_var_q[3];
  assign gyro_var_y_o   = out_var_q[4];
  assign gyro_var_z_o   = out_var_q[5];

  // the divider is never asked to start while it is still iterating
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a new result appears only after the last axis has been finished
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside hand-over");

  // the sample count never wraps to zero
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0)
    else $error("sample count is zero");

endmodule

### rtl/core/imurmv_div.sv
// ----------------------------------------------------------------------------
// imurmv_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module imurmv_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  imurmv_pkg::div_req_t                req_i,
  input  logic [imurmv_pkg::DVD_W-1:0]        dividend_i,
  input  logic [imurmv_pkg::COUNT_BITS-1:0]   divisor_i,
  output imurmv_pkg::div_rsp_t                rsp_o,
  output logic [imurmv_pkg::DVD_W-1:0]        quot_o,
  output logic [imurmv_pkg::COUNT_BITS-1:0]   rem_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [imurmv_pkg::LEN_W-1:0]        cnt_q;
  logic [imurmv_pkg::DVD_W-1:0]        dvd_q;
  logic [imurmv_pkg::DVD_W-1:0]        quo_q;
  logic [imurmv_pkg::COUNT_BITS-1:0]   rem_q;

  logic [imurmv_pkg::COUNT_BITS:0]     trial;
  logic [imurmv_pkg::COUNT_BITS:0]     diff;
  logic                                ge;
  logic [imurmv_pkg::COUNT_BITS-1:0]   rem_d;

  // dividend enters msb first, pre-aligned by the caller
  assign trial = {rem_q, dvd_q[imurmv_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});
  assign rem_d = ge ? diff[imurmv_pkg::COUNT_BITS-1:0] : trial[imurmv_pkg::COUNT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == imurmv_pkg::LEN_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.len;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[imurmv_pkg::DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[imurmv_pkg::DVD_W-2:0], ge};
    end else if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      quo_q <= '0;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = quo_q;
  assign rem_o      = rem_q;

endmodule
